FILE: design/pcj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcj_pkg
// Shared types, constants and palette tables for the hue jitter pipeline.
// ----------------------------------------------------------------------------
package pcj_pkg;

    // Fixed-point formats: channels, s and v are 0.FRAC_BITS, hue is 0.HUE_BITS.
    localparam int FRAC_BITS = 16;
    localparam int HUE_BITS  = 20;
    localparam int CH_W      = FRAC_BITS + 1;

    // Golden-ratio hash multiplier, split into 32-bit halves.
    localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
    localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;

    // Weights of the 16-bit chunks of a 64-bit word modulo 10000.
    localparam logic [12:0] W16 = 13'd5536;
    localparam logic [12:0] W32 = 13'd7296;
    localparam logic [12:0] W48 = 13'd656;

    // Reciprocal for the final modulo 10000 of a value below 2^30.
    localparam logic [30:0] MOD_RECIP = 31'd1759218605;
    localparam int          MOD_SH    = 44;
    localparam logic [13:0] HASH_MOD  = 14'd10000;
    localparam logic [13:0] HASH_MID  = 14'd5000;

    // Reciprocal for the division by 15625 of the scaled hue offset.
    localparam logic [31:0] SHIFT_RECIP = 32'd2251799814;
    localparam int          SHIFT_SH    = 45;

    // Control and colour information that rides along the pipeline.
    typedef struct packed {
        logic       zero;
        logic [2:0] kind;
        logic [7:0] alpha;
    } t_side;

    // Base palette colour, red in the top byte.
    function automatic logic [23:0] base_rgb(input logic [2:0] kind);
        logic [23:0] rgb;
        case (kind)
            3'd0:    rgb = 24'h7FB2FF;
            3'd1:    rgb = 24'hFFC46B;
            3'd2:    rgb = 24'hFF7A6B;
            3'd3:    rgb = 24'hB98CFF;
            3'd4:    rgb = 24'h7FE0A8;
            default: rgb = 24'hCFCFCF;
        endcase
        return rgb;
    endfunction

    // Alpha per tier; the unused code reads as the author level.
    function automatic logic [7:0] tier_alpha(input logic [1:0] tier);
        logic [7:0] a;
        case (tier)
            2'd1:    a = 8'hB0;
            2'd2:    a = 8'h60;
            default: a = 8'hE0;
        endcase
        return a;
    endfunction

    // Hue of each base colour, 0.20 turns.
    function automatic logic [HUE_BITS-1:0] kind_hue(input logic [2:0] kind);
        logic [HUE_BITS-1:0] h;
        case (kind)
            3'd0:    h = 20'd629418;
            3'd1:    h = 20'd105093;
            3'd2:    h = 20'd17712;
            3'd3:    h = 20'd767436;
            3'd4:    h = 20'd423394;
            default: h = 20'd0;
        endcase
        return h;
    endfunction

    // Chroma c = (v * s) >> FRAC_BITS of each base colour.
    function automatic logic [CH_W-1:0] kind_c(input logic [2:0] kind);
        logic [CH_W-1:0] c;
        case (kind)
            3'd0:    c = 17'd32896;
            3'd1:    c = 17'd38036;
            3'd2:    c = 17'd38036;
            3'd3:    c = 17'd29555;
            3'd4:    c = 17'd24928;
            default: c = 17'd0;
        endcase
        return c;
    endfunction

    // Offset m = v - c of each base colour.
    function automatic logic [CH_W-1:0] kind_m(input logic [2:0] kind);
        logic [CH_W-1:0] m;
        case (kind)
            3'd0:    m = 17'd32640;
            3'd1:    m = 17'd27500;
            3'd2:    m = 17'd27500;
            3'd3:    m = 17'd35981;
            3'd4:    m = 17'd32640;
            default: m = 17'd53199;
        endcase
        return m;
    endfunction

endpackage

FILE: design/pcj_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcj_hash
// Three stages: golden-ratio product mod 2^64 and its folding modulo 10000.
// ----------------------------------------------------------------------------
module pcj_hash (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [63:0]        i_id,
    input  pcj_pkg::t_side     i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [29:0]        o_fold,
    output pcj_pkg::t_side     o_side
);

    logic [2:0]           r_v;
    logic [2:0]           en;
    logic [63:0]          r_p00;
    logic [31:0]          r_p01;
    logic [31:0]          r_p10;
    logic [63:0]          r_h;
    logic [29:0]          r_fold;
    pcj_pkg::t_side       r_s0, r_s1, r_s2;
    logic [63:0]          n_h;
    logic [29:0]          n_fold;

    // A stage advances when it is empty or the next one advances.
    assign en[2]   = !r_v[2] || i_ready;
    assign en[1]   = !r_v[1] || en[2];
    assign en[0]   = !r_v[0] || en[1];
    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    // Low 64 bits of the product from three partial products.
    assign n_h = r_p00 + {r_p01 + r_p10, 32'd0};

    // Fold the 16-bit chunks with their weights modulo 10000.
    assign n_fold = 30'(r_h[15:0])
                  + 30'(r_h[31:16]) * 30'(pcj_pkg::W16)
                  + 30'(r_h[47:32]) * 30'(pcj_pkg::W32)
                  + 30'(r_h[63:48]) * 30'(pcj_pkg::W48);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_p00 <= 64'(i_id[31:0]) * 64'(pcj_pkg::HASH_MUL_LO);
            r_p01 <= 32'(i_id[31:0] * pcj_pkg::HASH_MUL_HI);
            r_p10 <= 32'(i_id[63:32] * pcj_pkg::HASH_MUL_LO);
            r_s0  <= i_side;
        end
        if (en[1]) begin
            r_h  <= n_h;
            r_s1 <= r_s0;
        end
        if (en[2]) begin
            r_fold <= n_fold;
            r_s2   <= r_s1;
        end
    end

    assign o_valid = r_v[2];
    assign o_fold  = r_fold;
    assign o_side  = r_s2;

endmodule

FILE: design/pcj_shift.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcj_shift
// Three stages: final modulo 10000 and the signed hue offset in 0.20 turns.
// ----------------------------------------------------------------------------
module pcj_shift (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [29:0]        i_fold,
    input  pcj_pkg::t_side     i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_neg,
    output logic [18:0]        o_mag,
    output pcj_pkg::t_side     o_side
);

    logic [2:0]           r_v;
    logic [2:0]           en;
    logic [29:0]          r_x;
    logic [16:0]          r_q;
    logic                 r_neg0, r_neg1;
    logic [30:0]          r_y;
    logic [18:0]          r_mag;
    pcj_pkg::t_side       r_s0, r_s1, r_s2;
    logic [60:0]          prod_q;
    logic [13:0]          rem;
    logic [12:0]          mid_dist;
    logic [63:0]          prod_m;

    assign en[2]   = !r_v[2] || i_ready;
    assign en[1]   = !r_v[1] || en[2];
    assign en[0]   = !r_v[0] || en[1];
    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    // Quotient by 10000 through the reciprocal; exact for folds below 2^30.
    assign prod_q = 61'(i_fold) * 61'(pcj_pkg::MOD_RECIP);

    // Remainder, distance from the midpoint, and scaling by 14 * 2^20 / 64.
    always_comb begin
        rem      = 14'(r_x - 30'(r_q) * 30'(pcj_pkg::HASH_MOD));
        mid_dist = (rem < pcj_pkg::HASH_MID) ? 13'(pcj_pkg::HASH_MID - rem)
                                             : 13'(rem - pcj_pkg::HASH_MID);
    end

    // Division by 15625 through the reciprocal, truncated toward zero.
    assign prod_m = 64'(r_y) * 64'(pcj_pkg::SHIFT_RECIP);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x  <= i_fold;
            r_q  <= prod_q[pcj_pkg::MOD_SH +: 17];
            r_s0 <= i_side;
        end
        if (en[1]) begin
            r_neg0 <= (rem < pcj_pkg::HASH_MID);
            r_y    <= 31'({({5'd0, mid_dist, 3'd0} - {8'd0, mid_dist}), 15'd0});
            r_s1   <= r_s0;
        end
        if (en[2]) begin
            r_neg1 <= r_neg0;
            r_mag  <= prod_m[pcj_pkg::SHIFT_SH +: 19];
            r_s2   <= r_s1;
        end
    end

    assign o_valid = r_v[2];
    assign o_neg   = r_neg1;
    assign o_mag   = r_mag;
    assign o_side  = r_s2;

endmodule

FILE: design/pcj_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcj_rgb
// Three stages: hue rotation, sector and secondary chroma, and RGB output.
// ----------------------------------------------------------------------------
module pcj_rgb (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_neg,
    input  logic [18:0]        i_mag,
    input  pcj_pkg::t_side     i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_rgba
);

    localparam int HB = pcj_pkg::HUE_BITS;
    localparam int CW = pcj_pkg::CH_W;

    logic [2:0]           r_v;
    logic [2:0]           en;
    logic [2:0]           r_sec0, r_sec1;
    logic [HB:0]          r_fsel;
    logic [CW-1:0]        r_x;
    logic [31:0]          r_rgba;
    pcj_pkg::t_side       r_s0, r_s1;
    logic [HB-1:0]        newh;
    logic [HB+2:0]        tt;
    logic [HB-1:0]        frac;
    logic [CW+HB:0]       prod_x;
    logic [CW-1:0]        cc, mm;
    logic [CW-1:0]        ro, go, bo;
    logic [23:0]          rgb_out;

    assign en[2]   = !r_v[2] || i_ready;
    assign en[1]   = !r_v[1] || en[2];
    assign en[0]   = !r_v[0] || en[1];
    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    // Rotate the hue, wrapped to one turn, and split six times it.
    always_comb begin
        newh = i_neg ? pcj_pkg::kind_hue(i_side.kind) - HB'(i_mag)
                     : pcj_pkg::kind_hue(i_side.kind) + HB'(i_mag);
        tt   = {1'b0, newh, 2'b00} + {2'b00, newh, 1'b0};
        frac = tt[HB-1:0];
    end

    // Secondary chroma from the position inside the sector.
    assign prod_x = (CW+HB+1)'(pcj_pkg::kind_c(r_s0.kind)) * (CW+HB+1)'(r_fsel);

    // Map the sector pattern onto the channels and convert to bytes.
    function automatic logic [7:0] to_byte(input logic [CW-1:0] val);
        logic [CW+7:0] p;
        p = {val, 8'd0} - (CW+8)'(val);
        return (p[CW+7:pcj_pkg::FRAC_BITS] > 8'd255) ? 8'hFF : p[pcj_pkg::FRAC_BITS +: 8];
    endfunction

    always_comb begin
        cc = pcj_pkg::kind_c(r_s1.kind);
        mm = pcj_pkg::kind_m(r_s1.kind);
        case (r_sec1)
            3'd0:    begin ro = cc;  go = r_x; bo = '0;  end
            3'd1:    begin ro = r_x; go = cc;  bo = '0;  end
            3'd2:    begin ro = '0;  go = cc;  bo = r_x; end
            3'd3:    begin ro = '0;  go = r_x; bo = cc;  end
            3'd4:    begin ro = r_x; go = '0;  bo = cc;  end
            default: begin ro = cc;  go = '0;  bo = r_x; end
        endcase
        if (r_s1.zero) begin
            rgb_out = pcj_pkg::base_rgb(r_s1.kind);
        end else begin
            rgb_out = {to_byte(ro + mm), to_byte(go + mm), to_byte(bo + mm)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_sec0 <= tt[HB+2:HB];
            r_fsel <= tt[HB] ? (HB+1)'((1 << HB)) - (HB+1)'(frac) : (HB+1)'(frac);
            r_s0   <= i_side;
        end
        if (en[1]) begin
            r_sec1 <= r_sec0;
            r_x    <= prod_x[HB +: CW];
            r_s1   <= r_s0;
        end
        if (en[2]) begin
            r_rgba <= {rgb_out, r_s1.alpha};
        end
    end

    assign o_valid = r_v[2];
    assign o_rgba  = r_rgba;

endmodule

FILE: design/palette_colour_hue_jitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_colour_hue_jitter
// Per-instance palette colour with a hashed hue rotation of up to +/-7%.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one word per identifier: the 64-bit identifier
//   in tdata, and the colour kind and alpha tier in tuser. The master channel
//   returns one packed RGBA word per input word, in order.
//   Identifier zero returns the plain palette colour with the tier alpha.
//   The pipeline between acceptance and tvalid on the master side is
//   made of three three-stage units: the hash multiply and fold, the
//   reciprocal modulo and hue offset scaling, and the HSV to RGB conversion.
//   Throughput is one word per cycle while the receiver keeps tready high.
//   When the receiver stalls, the final word is held and earlier stages keep
//   filling any empty slots, so the slave side stays ready until all nine
//   stages hold words. Reset empties the pipeline; no words are in flight
//   afterwards and there is no clearing phase.
// ----------------------------------------------------------------------------
module palette_colour_hue_jitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // link_id[63:0]
    input  logic [4:0]  i_s_tuser,   // link_kind[2:0], tier[4:3]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // rgba[31:0]
);

    pcj_pkg::t_side in_side, h_side, s_side;
    logic           h_valid, h_ready, s_valid, s_ready;
    logic [29:0]    h_fold;
    logic           s_neg;
    logic [18:0]    s_mag;

    // Side information decoded at the input.
    always_comb begin
        in_side.zero  = (i_s_tdata == 64'd0);
        in_side.kind  = i_s_tuser[2:0];
        in_side.alpha = pcj_pkg::tier_alpha(i_s_tuser[4:3]);
    end

    pcj_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_id    (i_s_tdata),
        .i_side  (in_side),
        .o_valid (h_valid),
        .i_ready (h_ready),
        .o_fold  (h_fold),
        .o_side  (h_side)
    );

    pcj_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (h_valid),
        .o_ready (h_ready),
        .i_fold  (h_fold),
        .i_side  (h_side),
        .o_valid (s_valid),
        .i_ready (s_ready),
        .o_neg   (s_neg),
        .o_mag   (s_mag),
        .o_side  (s_side)
    );

    pcj_rgb u_rgb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .o_ready (s_ready),
        .i_neg   (s_neg),
        .i_mag   (s_mag),
        .i_side  (s_side),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_rgba  (o_m_tdata)
    );

    // Every delivered word carries one of the three tier alphas.
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:0] == 8'hE0 || o_m_tdata[7:0] == 8'hB0 ||
                        o_m_tdata[7:0] == 8'h60))
        else $error("output alpha is not a tier alpha");

    // With the output stage empty the whole pipeline can advance.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output stage is empty");

    // The hue offset never exceeds seven percent of a turn.
    a_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_valid |-> (s_mag <= 19'd73400))
        else $error("hue offset out of range");

    // Reset leaves no word on the output.
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule
